/* hw/rtl/ofdm_cp_removal_dft_demodulator_top_defines.svh */
// Assertion macros for the OFDM demodulator.
`ifndef OFDM_CP_REMOVAL_DFT_DEMODULATOR_TOP_DEFINES_SVH
`define OFDM_CP_REMOVAL_DFT_DEMODULATOR_TOP_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define OCD_ASSERT_IMP(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define OCD_ASSERT_NXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`endif

/* hw/rtl/ocd_pkg.sv */
// Shared constants, types and the twiddle table of the OFDM demodulator.
package ocd_pkg;
   localparam int FftSize = 64;
   localparam int SymbolsPerSlot = 14;
   localparam int MaxResults = 64;
   localparam int AW = $clog2(FftSize);
   localparam int CW = AW + 1;

   typedef enum logic [2:0] {
      CSR_CP_NORMAL = 3'd0,
      CSR_CP_LONG = 3'd1,
      CSR_ACTIVE = 3'd2,
      CSR_SYM_PER_SF = 3'd3,
      CSR_LONG_POS = 3'd4,
      CSR_SLOTS = 3'd5
   } csr_index_type;

   // round(32767*sin(pi/2*r/64)), r = 0..64
   localparam logic [15:0] QuarterTab [0:64] = '{
      16'd0, 16'd804, 16'd1608, 16'd2410, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
      16'd6393, 16'd7179, 16'd7962, 16'd8739, 16'd9512, 16'd10278, 16'd11039, 16'd11793,
      16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
      16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
      16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
      16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
      16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
      16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
      16'd32767
   };

   // round(32767*sin(2*pi*idx/256)) for an 8-bit phase
   function automatic logic signed [16:0] sin_at(input logic [7:0] idx);
      logic [1:0] q;
      logic [5:0] rem;
      logic [15:0] mag;
      q = idx[7:6];
      rem = idx[5:0];
      mag = q[0] ? QuarterTab[7'd64 - {1'b0, rem}] : QuarterTab[{1'b0, rem}];
      return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction
endpackage

/* hw/rtl/ocd_ram.sv */
// Generic single-port-write, registered-read RAM.
module ocd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* hw/rtl/ofdm_cp_removal_dft_demodulator_top.sv */
// Top level: cyclic prefix removal, sample store and serial DFT.
//  channel | direction | content
//  req     | in        | one time sample and stream start
//  rsp     | out       | one DFT bin with its tags
//  csr     | in        | register writes
// Samples are taken one per cycle while a symbol fills. The transform is a single
// multiply-accumulate over the sample memory: with N = 64 points, each bin reads and
// accumulates all N samples, then loads the output register and waits for transfer.
// After the last sample of a symbol, req_tready stays low until all active bins of the
// symbol have been transferred. Reset is synchronous; rsp stalls hold the bin.
`include "ofdm_cp_removal_dft_demodulator_top_defines.svh"
module ofdm_cp_removal_dft_demodulator_top
   import ocd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // sample_i, sample_q
   input  logic        req_tuser,  // stream_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // bin_i, bin_q, bin_index, symbol tag, slot tag
   output logic        rsp_tlast,  // last_bin
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   typedef enum logic [1:0] {S_FILL, S_MAC, S_OUT} state_type;

   state_type state_ff;
   logic [6:0] cpn_ff, cpl_ff, act_ff;
   logic [5:0] spsf_ff, lpos_ff, spf_ff;
   logic [7:0] pos_ff;
   logic [5:0] sfc_ff, fsc_ff;
   logic [3:0] ssc_ff;
   logic [6:0] k_ff, cnt_ff;
   logic [CW:0] n_ff;
   logic signed [47:0] re_ff, im_ff;
   logic [3:0] symtag_ff;
   logic [5:0] slottag_ff;
   logic [AW-1:0] a_ff;
   logic rv_ff;
   logic [79:0] dout_ff;
   logic last_ff;

   logic req_fire, start;
   logic [7:0] pos_in;
   logic [5:0] sfc_in;
   logic [6:0] cp;
   logic [7:0] idx;
   logic sym_end;
   logic [31:0] rd_data;
   logic [AW-1:0] rd_addr;
   logic signed [16:0] tw_c, tw_s;
   logic signed [15:0] xi, xq;
   logic signed [32:0] p_ic, p_qs, p_is, p_qc;
   logic signed [47:0] re_sum, im_sum;
   logic [31:0] sat_re, sat_im;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_FILL);
   assign start = req_tuser;
   assign pos_in = start ? 8'd0 : pos_ff;
   assign sfc_in = start ? 6'd0 : sfc_ff;
   assign cp = (sfc_in == 6'd0 || sfc_in == lpos_ff) ? cpl_ff : cpn_ff;
   assign idx = pos_in - {1'b0, cp};
   assign sym_end = ({1'b0, pos_in} + 9'd1) >= ({2'b0, cp} + 9'(FftSize));

   assign rd_addr = n_ff[AW-1:0];
   ocd_ram #(.WIDTH(32), .DEPTH(FftSize)) u_ram (
      .clock  (clock),
      .wr_en  (req_fire && pos_in >= {1'b0, cp} && idx < 8'(FftSize)),
      .wr_addr(idx[AW-1:0]),
      .wr_data(req_tdata),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // phase of the sample being read back: k*n mod N, registered with read
   assign tw_c = sin_at({a_ff, 2'b00} + 8'(FftSize));
   assign tw_s = -sin_at({a_ff, 2'b00});
   assign xi = rd_data[15:0];
   assign xq = rd_data[31:16];
   assign p_ic = xi * tw_c;
   assign p_qs = xq * tw_s;
   assign p_is = xi * tw_s;
   assign p_qc = xq * tw_c;
   assign re_sum = re_ff + 48'(p_ic) - 48'(p_qs);
   assign im_sum = im_ff + 48'(p_is) + 48'(p_qc);

   function automatic logic [31:0] shsat(input logic signed [47:0] v);
      logic signed [32:0] r;
      r = 33'(v >>> 15);
      if (r > 33'sd2147483647) return 32'h7fffffff;
      if (r < -33'sd2147483648) return 32'h80000000;
      return r[31:0];
   endfunction
   assign sat_re = shsat(re_ff);
   assign sat_im = shsat(im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL;
         cpn_ff <= 7'd4; cpl_ff <= 7'd5; act_ff <= 7'd48;
         spsf_ff <= 6'd28; lpos_ff <= 6'd14; spf_ff <= 6'd20;
         pos_ff <= '0; sfc_ff <= '0; ssc_ff <= '0; fsc_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CP_NORMAL: cpn_ff <= csr_wdata;
               CSR_CP_LONG: cpl_ff <= csr_wdata;
               CSR_ACTIVE: act_ff <= csr_wdata;
               CSR_SYM_PER_SF: spsf_ff <= csr_wdata[5:0];
               CSR_LONG_POS: lpos_ff <= csr_wdata[5:0];
               CSR_SLOTS: spf_ff <= csr_wdata[5:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_FILL: begin
               if (req_fire) begin
                  if (!sym_end) begin
                     pos_ff <= pos_in + 8'd1;
                     if (start) begin
                        sfc_ff <= '0; ssc_ff <= '0; fsc_ff <= '0;
                     end
                  end else begin
                     pos_ff <= '0;
                     symtag_ff <= start ? 4'd0 : ssc_ff;
                     slottag_ff <= start ? 6'd0 : fsc_ff;
                     sfc_ff <= (sfc_in + 6'd1 >= spsf_ff) ? 6'd0 : sfc_in + 6'd1;
                     if ((start ? 4'd0 : ssc_ff) + 4'd1 >= 4'(SymbolsPerSlot)) begin
                        ssc_ff <= '0;
                        fsc_ff <= ((start ? 6'd0 : fsc_ff) + 6'd1 >= spf_ff) ? 6'd0
                                  : (start ? 6'd0 : fsc_ff) + 6'd1;
                     end else begin
                        ssc_ff <= (start ? 4'd0 : ssc_ff) + 4'd1;
                        if (start) fsc_ff <= '0;
                     end
                     cnt_ff <= (act_ff > 7'(FftSize)) ? 7'(FftSize) : act_ff;
                     k_ff <= '0;
                     n_ff <= '0;
                     re_ff <= '0; im_ff <= '0;
                     if (act_ff != 7'd0) state_ff <= S_MAC;
                  end
               end
            end
            S_MAC: begin
               // n_ff issues reads; the registered read data is accumulated in the following cycle
               a_ff <= 6'(k_ff[AW-1:0] * rd_addr);
               if (n_ff >= (CW+1)'(1)) begin
                  re_ff <= re_sum; im_ff <= im_sum;
               end
               if (n_ff == (CW+1)'(FftSize)) begin
                  state_ff <= S_OUT;
               end else begin
                  n_ff <= n_ff + 1'b1;
               end
            end
            S_OUT: begin
               if (!rv_ff || rsp_tready) begin
                  if (!rv_ff) begin
                     rv_ff <= 1'b1;
                     dout_ff <= {slottag_ff, symtag_ff, k_ff[5:0], sat_im, sat_re};
                     last_ff <= (k_ff + 7'd1 == cnt_ff);
                  end else begin
                     rv_ff <= 1'b0;
                     if (k_ff + 7'd1 == cnt_ff) begin
                        state_ff <= S_FILL;
                     end else begin
                        k_ff <= k_ff + 7'd1;
                        n_ff <= '0; re_ff <= '0; im_ff <= '0;
                        state_ff <= S_MAC;
                     end
                  end
               end
            end
            default: state_ff <= S_FILL;
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = dout_ff;
   assign rsp_tlast = last_ff;

   `OCD_ASSERT_IMP(a_out_state, clock, reset, rsp_tvalid, state_ff == S_OUT, "bin outside output state")
   `OCD_ASSERT_IMP(a_no_req, clock, reset, state_ff != S_FILL, !req_tready, "sample taken during DFT")
   `OCD_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "stalled bin changed")
endmodule
